@@ hw/rtl/owrb_pkg.sv @@
// ---------------------------------------------------------------------------
// owrb_pkg
// Shared types and constants of the overwriting ring buffer.
// ---------------------------------------------------------------------------
package owrb_pkg;

	localparam int DEPTH   = 16;
	localparam int WORD_W  = 32;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int CMD_W   = 2;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

	typedef struct packed {
		logic             rd;
		logic             fail;
		logic [CNT_W-1:0] fill_count;
		logic [PTR_W-1:0] head_index;
		logic             empty_res;
	} meta_t;

endpackage

@@ hw/rtl/owrb_if.sv @@
// ---------------------------------------------------------------------------
// owrb_cmd_if / owrb_res_if
// Valid/ready channels for commands and results.
// ---------------------------------------------------------------------------
interface owrb_cmd_if import owrb_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [WORD_W-1:0] data_in;
	logic [CNT_W-1:0]         offset;

	modport source (output valid, cmd, data_in, offset, input ready);
	modport sink (input valid, cmd, data_in, offset, output ready);
endinterface

interface owrb_res_if import owrb_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] data_out;
	logic                     fail;
	logic [CNT_W-1:0]         fill_count;
	logic [PTR_W-1:0]         head_index;
	logic                     empty_res;

	modport source (output valid, data_out, fail, fill_count, head_index, empty_res,
		input ready);
	modport sink (input valid, data_out, fail, fill_count, head_index, empty_res,
		output ready);
endinterface

@@ hw/rtl/owrb_ram.sv @@
// ---------------------------------------------------------------------------
// owrb_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module owrb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/overwriting_ring_buffer_top.sv @@
// ---------------------------------------------------------------------------
// overwriting_ring_buffer_top
// Ring buffer of signed words with run-time capacity; overwrites when full.
//
//   channel  dir  handshake           payload
//   cmd_ch   in   valid/ready         cmd, data_in, offset
//   res_ch   out  valid/ready         data_out, fail, fill_count, head_index,
//                                     empty_res
//   apb      in   psel/penable/pready capacity at byte address 0
//
// One command per cycle while the input is not blocked. Pointers, the slot
// write and the slot read are all taken at the accepting edge, the read word
// landing in the RAM output register; the result register takes it when
// stage 1 advances. A stalled result lets one more command wait in stage 1,
// its read word kept in a hold register, and then blocks the input. Each
// command makes one RAM read and at most one RAM write. Reset empties the
// buffer and sets capacity to the full depth; slot contents are not cleared.
// ---------------------------------------------------------------------------
module overwriting_ring_buffer_top import owrb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	owrb_cmd_if.sink           cmd_ch,
	owrb_res_if.source         res_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [CNT_W-1:0] cap_q;
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] held_q;

	logic             v_s1;
	meta_t            meta_s1;
	logic             rd_new_q;
	logic [WORD_W-1:0] rdata_s1;
	logic             out_v_q;
	meta_t            out_meta_q;
	logic [WORD_W-1:0] out_data_q;

	logic [CNT_W-1:0] cap_eff;
	logic             cfg_wr;
	logic             s1_adv, acc;

	logic [PTR_W-1:0] head_nx, tail_nx, head_inc, tail_inc;
	logic [CNT_W-1:0] held_nx;
	logic [CNT_W-1:0] peek_sum;
	logic             we;
	logic [PTR_W-1:0] waddr, raddr;
	logic [WORD_W-1:0] wdata, rdata;
	meta_t            meta_nx;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_CAPACITY);
	assign cfg_wr  = psel && penable && pwrite && reg_sel;
	assign prdata  = reg_sel ? PDATA_W'(cap_q) : '0;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (cap_q > CNT_W'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	assign s1_adv = !out_v_q || res_ch.ready;
	assign cmd_ch.ready = !v_s1 || s1_adv;
	assign acc = cmd_ch.valid && cmd_ch.ready;

	assign head_inc = (CNT_W'(head_q) == cap_eff - CNT_W'(1)) ? '0 : head_q + PTR_W'(1);
	assign tail_inc = (CNT_W'(tail_q) == cap_eff - CNT_W'(1)) ? '0 : tail_q + PTR_W'(1);
	assign peek_sum = CNT_W'(head_q) + cmd_ch.offset - CNT_W'(1);

	always_comb begin
		head_nx = head_q;
		tail_nx = tail_q;
		held_nx = held_q;
		we      = 1'b0;
		waddr   = head_q;
		wdata   = '0;
		raddr   = head_q;
		meta_nx = '0;
		case (cmd_t'(cmd_ch.cmd))
			CMD_PUSH: begin
				we      = 1'b1;
				waddr   = tail_q;
				wdata   = cmd_ch.data_in;
				tail_nx = tail_inc;
				if (held_q < cap_eff) begin
					held_nx = held_q + CNT_W'(1);
				end else begin
					head_nx = head_inc;
				end
			end
			CMD_POP: begin
				if (held_q == '0) begin
					meta_nx.fail = 1'b1;
				end else begin
					meta_nx.rd = 1'b1;
					we         = 1'b1;
					head_nx    = head_inc;
					held_nx    = held_q - CNT_W'(1);
				end
			end
			CMD_PEEK: begin
				if (cmd_ch.offset == '0 || cmd_ch.offset > held_q) begin
					meta_nx.fail = 1'b1;
				end else begin
					meta_nx.rd = 1'b1;
					raddr = (peek_sum >= cap_eff) ? PTR_W'(peek_sum - cap_eff)
						: PTR_W'(peek_sum);
				end
			end
			default: begin
				we = 1'b1;
			end
		endcase
		meta_nx.fill_count = held_nx;
		meta_nx.head_index = head_nx;
		meta_nx.empty_res  = (held_nx == '0);
	end

	owrb_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (we && acc),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CNT_W'(DEPTH);
			head_q   <= '0;
			tail_q   <= '0;
			held_q   <= '0;
			v_s1     <= 1'b0;
			rd_new_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				cap_q  <= pwdata[CNT_W-1:0];
				head_q <= '0;
				tail_q <= '0;
				held_q <= '0;
			end else if (acc) begin
				head_q <= head_nx;
				tail_q <= tail_nx;
				held_q <= held_nx;
			end
			if (cmd_ch.ready) begin
				v_s1 <= acc;
			end
			rd_new_q <= acc;
			if (s1_adv) begin
				out_v_q <= v_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			meta_s1 <= meta_nx;
		end
		// keep the read word while stage 1 waits
		if (rd_new_q) begin
			rdata_s1 <= rdata;
		end
		if (s1_adv && v_s1) begin
			out_meta_q <= meta_s1;
			out_data_q <= meta_s1.rd ? (rd_new_q ? rdata : rdata_s1) : '0;
		end
	end

	assign res_ch.valid      = out_v_q;
	assign res_ch.data_out   = out_data_q;
	assign res_ch.fail       = out_meta_q.fail;
	assign res_ch.fill_count = out_meta_q.fill_count;
	assign res_ch.head_index = out_meta_q.head_index;
	assign res_ch.empty_res  = out_meta_q.empty_res;

endmodule

@@ sim/overwriting_ring_buffer_top_tb.sv @@
// ---------------------------------------------------------------------------
// overwriting_ring_buffer_top_tb
// Self-checking bench for the overwriting ring buffer. Commands go in on the
// command channel and every accepted command is run through a cycle-free copy
// of the ring (slots, head, tail, fill count, capacity). The status it yields
// is queued and compared field by field with each result transaction. Directed
// commands cover the empty buffer, word extremes, peek bounds and overwrite at
// tiny capacities. Random traffic then runs under many capacity settings,
// out-of-range ones too, with random gaps on both channels.
// ---------------------------------------------------------------------------
module overwriting_ring_buffer_top_tb import owrb_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	localparam int PHASES      = 12;
	localparam int PHASE_CMDS  = 75;

	typedef struct {
		logic signed [WORD_W-1:0] data;
		logic                     fail;
		logic [CNT_W-1:0]         count;
		logic [PTR_W-1:0]         head;
		logic                     empty;
	} ring_status_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	owrb_cmd_if cmd_ch ();
	owrb_res_if res_ch ();

	overwriting_ring_buffer_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_ch  (cmd_ch),
		.res_ch  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic signed [WORD_W-1:0] ring_mem [DEPTH];
	int                       ring_head;
	int                       ring_tail;
	int                       ring_held;
	logic [CNT_W-1:0]         cap_reg;
	ring_status_t             pending_results [$];

	int mismatches   = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int failed_ops   = 0;
	int overwrites   = 0;
	int cap_writes   = 0;
	int cycle_count  = 0;
	bit src_idle;
	bit snk_idle;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic void predict_status(cmd_t c, logic signed [WORD_W-1:0] word,
		logic [CNT_W-1:0] off);
		int           span;
		ring_status_t s;
		span = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
		s.data = '0;
		s.fail = 1'b0;
		case (c)
			CMD_PUSH: begin
				ring_mem[ring_tail] = word;
				if (ring_held < span) begin
					ring_held++;
				end else begin
					ring_head = (ring_head + 1) % span;
					overwrites++;
				end
				ring_tail = (ring_tail + 1) % span;
			end
			CMD_POP: begin
				if (ring_held == 0) begin
					s.fail = 1'b1;
				end else begin
					s.data = ring_mem[ring_head];
					ring_mem[ring_head] = '0;
					ring_head = (ring_head + 1) % span;
					ring_held--;
				end
			end
			CMD_PEEK: begin
				if (off == 0 || int'(off) > ring_held) begin
					s.fail = 1'b1;
				end else begin
					s.data = ring_mem[(ring_head + int'(off) - 1) % span];
				end
			end
			default: begin
				ring_mem[ring_head] = '0;
			end
		endcase
		s.count = CNT_W'(ring_held);
		s.head  = PTR_W'(ring_head);
		s.empty = (ring_held == 0);
		if (s.fail) failed_ops++;
		pending_results.push_back(s);
	endfunction

	// valid is left high after acceptance; the next call or settle_ring moves it
	task automatic send_cmd(cmd_t c, logic signed [WORD_W-1:0] word, logic [CNT_W-1:0] off);
		int gap;
		gap = src_idle ? $urandom_range(0, 15) : 0;
		repeat (gap) begin
			@(negedge clk);
			cmd_ch.valid = 1'b0;
		end
		@(negedge clk);
		cmd_ch.valid   = 1'b1;
		cmd_ch.cmd     = c;
		cmd_ch.data_in = word;
		cmd_ch.offset  = off;
		do @(posedge clk); while (!cmd_ch.ready);
		predict_status(c, word, off);
		items_sent++;
	endtask

	task automatic settle_ring();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CNT_W-1:0] value);
		settle_ring();
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {REG_CAPACITY, 2'b00};
		pwdata  = PDATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		cap_reg   = value;
		ring_head = 0;
		ring_tail = 0;
		ring_held = 0;
		cap_writes++;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	initial begin : result_sink
		int stall;
		forever begin
			stall = snk_idle ? $urandom_range(0, 15) : 0;
			repeat (stall) begin
				@(negedge clk);
				res_ch.ready = 1'b0;
			end
			@(negedge clk);
			res_ch.ready = 1'b1;
			do @(posedge clk); while (!(arst_n && res_ch.valid));
		end
	end

	always @(posedge clk) begin : result_check
		ring_status_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("cycle %0d: result with no command outstanding", cycle_count);
			end else begin
				want = pending_results.pop_front();
				if (res_ch.data_out !== want.data || res_ch.fail !== want.fail ||
					res_ch.fill_count !== want.count || res_ch.head_index !== want.head ||
					res_ch.empty_res !== want.empty) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("cycle %0d: exp data %0d fail %0b cnt %0d head %0d empty %0b",
							cycle_count, want.data, want.fail, want.count, want.head,
							want.empty);
						$display("          got data %0d fail %0b cnt %0d head %0d empty %0b",
							res_ch.data_out, res_ch.fail, res_ch.fill_count,
							res_ch.head_index, res_ch.empty_res);
					end
				end
			end
		end
	end

	task automatic test_empty_ops();
		send_cmd(CMD_POP, '0, '0);
		send_cmd(CMD_PEEK, '0, 5'd0);
		send_cmd(CMD_PEEK, '0, 5'd1);
		send_cmd(CMD_CLEAR, '0, '0);
	endtask

	task automatic test_push_peek_pop();
		send_cmd(CMD_PUSH, 32'sh7FFFFFFF, 5'd0);
		send_cmd(CMD_PUSH, 32'sh80000000, 5'd31);
		send_cmd(CMD_PUSH, -32'sd1, 5'd16);
		send_cmd(CMD_PUSH, 32'sd0, 5'd0);
		send_cmd(CMD_PEEK, -32'sd1, 5'd0);
		send_cmd(CMD_PEEK, '0, 5'd1);
		send_cmd(CMD_PEEK, '0, 5'd4);
		send_cmd(CMD_PEEK, '0, 5'd5);
		send_cmd(CMD_PEEK, '0, 5'd16);
		send_cmd(CMD_POP, '0, '0);
		send_cmd(CMD_CLEAR, '0, '0);
		send_cmd(CMD_POP, '0, '0);
		send_cmd(CMD_POP, '0, '0);
		send_cmd(CMD_POP, '0, '0);
		send_cmd(CMD_POP, '0, '0);
	endtask

	task automatic test_small_capacity();
		write_capacity(5'd1);
		send_cmd(CMD_PUSH, 32'sh12345678, '0);
		send_cmd(CMD_PUSH, 32'sh5A5A5A5A, '0);
		send_cmd(CMD_PEEK, '0, 5'd1);
		send_cmd(CMD_PEEK, '0, 5'd2);
		send_cmd(CMD_POP, '0, '0);
		write_capacity(5'd0);
		send_cmd(CMD_PUSH, 32'shA5A5A5A5, '0);
		send_cmd(CMD_PUSH, 32'sh0F0F0F0F, '0);
		send_cmd(CMD_POP, '0, '0);
	endtask

	task automatic test_random_traffic();
		int               caps [PHASES] = '{2, 16, 31, 3, 17, 8, 1, 5, 15, 0, 16, 0};
		int               t_push;
		int               t_pop;
		int               t_peek;
		int               pick;
		cmd_t             c;
		logic signed [WORD_W-1:0] word;
		logic [CNT_W-1:0] off;
		for (int p = 0; p < PHASES; p++) begin
			write_capacity((p == PHASES - 1) ? CNT_W'($urandom_range(0, 31)) : CNT_W'(caps[p]));
			src_idle = (p == 0) ? 1'b0 : ((p == 1) ? 1'b1 : bit'($urandom_range(0, 1)));
			snk_idle = (p == 0) ? 1'b0 : ((p == 1) ? 1'b1 : bit'($urandom_range(0, 1)));
			case (p % 3)
				0: begin t_push = 40; t_pop = 65; t_peek = 90; end
				1: begin t_push = 65; t_pop = 75; t_peek = 95; end
				default: begin t_push = 30; t_pop = 65; t_peek = 90; end
			endcase
			for (int n = 0; n < PHASE_CMDS; n++) begin
				// hold off mid-phase until the result queue is empty
				if (p % 4 == 2 && n == PHASE_CMDS / 2) settle_ring();
				pick = $urandom_range(0, 99);
				if (pick < t_push) c = CMD_PUSH;
				else if (pick < t_pop) c = CMD_POP;
				else if (pick < t_peek) c = CMD_PEEK;
				else c = CMD_CLEAR;
				case ($urandom_range(0, 9))
					0: word = 32'sh7FFFFFFF;
					1: word = 32'sh80000000;
					2: word = -32'sd1;
					default: word = $urandom;
				endcase
				pick = $urandom_range(0, 99);
				if (ring_held > 0 && pick < 75) off = CNT_W'($urandom_range(1, ring_held));
				else if (pick < 85) off = (ring_held < DEPTH) ? CNT_W'(ring_held + 1) : '0;
				else off = CNT_W'($urandom_range(0, DEPTH));
				send_cmd(c, word, off);
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.cmd     = CMD_PUSH;
		cmd_ch.data_in = '0;
		cmd_ch.offset  = '0;
		res_ch.ready   = 1'b0;
		cap_reg        = CNT_W'(DEPTH);
		ring_head      = 0;
		ring_tail      = 0;
		ring_held      = 0;
		foreach (ring_mem[i]) ring_mem[i] = '0;
		src_idle       = 1'b1;
		snk_idle       = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_ops();
		test_push_peek_pop();
		test_small_capacity();
		test_random_traffic();

		settle_ring();
		repeat (8) @(posedge clk);
		$display("%0d commands, %0d results checked over %0d capacity writes", items_sent,
			results_seen, cap_writes);
		$display("%0d failing pops/peeks, %0d overwriting pushes, %0d mismatches", failed_ops,
			overwrites, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
